// ----- design/cmfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cmfs_pkg
// Shared widths, face codes and the work word that travels down the
// cube map face select pipeline.
// ----------------------------------------------------------------------------
package cmfs_pkg;

  // Direction component width (signed) and texture coordinate width (unsigned)
  localparam int COMPONENT_BITS = 16;
  localparam int COORD_BITS     = 16;

  // Major magnitude reaches 2^(COMPONENT_BITS-1): one more bit than the payload
  localparam int MAG_W = COMPONENT_BITS;
  // Divisor is twice the major magnitude, up to 2^COMPONENT_BITS
  localparam int DEN_W = COMPONENT_BITS + 1;
  // Partial remainder stays below the divisor
  localparam int REM_W = DEN_W;
  localparam int FACE_W = 3;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // One item in flight: divisor, two partial remainders, two partial quotients
  typedef struct packed {
    face_t                 face;
    logic                  degen;
    logic                  sat_u;
    logic                  sat_v;
    logic [DEN_W-1:0]      den;
    logic [REM_W-1:0]      rem_u;
    logic [REM_W-1:0]      rem_v;
    logic [COORD_BITS-1:0] quo_u;
    logic [COORD_BITS-1:0] quo_v;
  } work_t;

endpackage

// ----- design/cmfs_front.sv -----
// ----------------------------------------------------------------------------
// cmfs_front
// Major axis selection, minor component swizzle and divider setup. One
// registered stage with a valid/ready handshake on both sides.
// ----------------------------------------------------------------------------
module cmfs_front (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        up_valid,
  output logic                                        up_ready,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0]  dir_x,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0]  dir_y,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0]  dir_z,
  output logic                                        dn_valid,
  input  logic                                        dn_ready,
  output cmfs_pkg::work_t                             dn_data
);
  import cmfs_pkg::*;

  localparam int SW = COMPONENT_BITS + 1;

  logic              valid_r, valid_nxt;
  work_t             data_r, data_nxt;

  logic signed [SW-1:0] sx, sy, sz, nx, ny, nz, ax, ay, az;
  logic signed [SW-1:0] sel_a, sel_b, sel_m;
  logic signed [SW:0]   num_a_s, num_b_s;
  logic [DEN_W-1:0]     num_a, num_b, den;
  face_t                sel_face;
  logic                 is_zero;

  // Widen so that the negated minimum value is exact
  assign sx = SW'(dir_x);
  assign sy = SW'(dir_y);
  assign sz = SW'(dir_z);
  assign nx = -sx;
  assign ny = -sy;
  assign nz = -sz;
  assign ax = sx[SW-1] ? nx : sx;
  assign ay = sy[SW-1] ? ny : sy;
  assign az = sz[SW-1] ? nz : sz;
  assign is_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

  // Pick the face; positive faces win ties, negative faces need a strict win,
  // and a tie between two negative maxima falls back to the first of them
  always_comb begin
    sel_face = FACE_POS_X;
    sel_a    = sz;
    sel_b    = sy;
    sel_m    = ax;
    if (is_zero) begin
      sel_face = FACE_POS_X;
      sel_a    = '0;
      sel_b    = '0;
      sel_m    = SW'(1);
    end else if (sx >= ay && sx >= az) begin
      sel_face = FACE_POS_X; sel_a = sz; sel_b = sy; sel_m = ax;
    end else if (nx > ay && nx > az) begin
      sel_face = FACE_NEG_X; sel_a = nz; sel_b = sy; sel_m = ax;
    end else if (sy >= az && sy >= ax) begin
      sel_face = FACE_POS_Y; sel_a = sx; sel_b = sz; sel_m = ay;
    end else if (ny > az && ny > ax) begin
      sel_face = FACE_NEG_Y; sel_a = sx; sel_b = nz; sel_m = ay;
    end else if (sz >= ax && sz >= ay) begin
      sel_face = FACE_POS_Z; sel_a = nx; sel_b = sy; sel_m = az;
    end else if (nz > ax && nz > ay) begin
      sel_face = FACE_NEG_Z; sel_a = sx; sel_b = sy; sel_m = az;
    end else if (nx >= ay && nx >= az) begin
      sel_face = FACE_NEG_X; sel_a = nz; sel_b = sy; sel_m = ax;
    end else if (ny >= az && ny >= ax) begin
      sel_face = FACE_NEG_Y; sel_a = sx; sel_b = nz; sel_m = ay;
    end else begin
      sel_face = FACE_NEG_Z; sel_a = sx; sel_b = sy; sel_m = az;
    end
  end

  // Numerator minor + |major| lies in [0, 2|major|]; divisor is 2|major|
  assign num_a_s = (SW+1)'(sel_a) + (SW+1)'(sel_m);
  assign num_b_s = (SW+1)'(sel_b) + (SW+1)'(sel_m);
  assign num_a   = num_a_s[DEN_W-1:0];
  assign num_b   = num_b_s[DEN_W-1:0];
  assign den     = {sel_m[MAG_W-1:0], 1'b0};

  // Build the work word; a full-scale numerator saturates, so start it at zero
  always_comb begin
    data_nxt       = data_r;
    valid_nxt      = valid_r;
    if (up_ready) begin
      valid_nxt      = up_valid;
      data_nxt.face  = sel_face;
      data_nxt.degen = is_zero;
      data_nxt.sat_u = (num_a == den);
      data_nxt.sat_v = (num_b == den);
      data_nxt.den   = den;
      data_nxt.rem_u = (num_a == den) ? '0 : num_a;
      data_nxt.rem_v = (num_b == den) ? '0 : num_b;
      data_nxt.quo_u = '0;
      data_nxt.quo_v = '0;
    end
  end

  // Hold the stage while downstream stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Divider entry condition: remainder starts below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.rem_u < data_r.den) && (data_r.rem_v < data_r.den))
    else $error("front: starting remainder not below divisor");

  // A zero vector always enters as face +x with no saturation
  a_degen_setup: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && data_r.degen |-> data_r.face == FACE_POS_X && !data_r.sat_u && !data_r.sat_v)
    else $error("front: bad zero-vector setup");

endmodule

// ----- design/cmfs_div_cell.sv -----
// ----------------------------------------------------------------------------
// cmfs_div_cell
// One restoring division step for both coordinates: shift the remainder,
// compare with the divisor, subtract, and shift one quotient bit in.
// ----------------------------------------------------------------------------
module cmfs_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cmfs_pkg::work_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cmfs_pkg::work_t dn_data
);
  import cmfs_pkg::*;

  logic             valid_r, valid_nxt;
  work_t            data_r, data_nxt;
  logic [REM_W:0]   sh_u, sh_v;
  logic             ge_u, ge_v;
  logic [REM_W:0]   diff_u, diff_v;

  // Shift the remainders and trial-subtract the divisor
  assign sh_u   = {up_data.rem_u, 1'b0};
  assign sh_v   = {up_data.rem_v, 1'b0};
  assign ge_u   = sh_u >= {1'b0, up_data.den};
  assign ge_v   = sh_v >= {1'b0, up_data.den};
  assign diff_u = sh_u - {1'b0, up_data.den};
  assign diff_v = sh_v - {1'b0, up_data.den};

  // Advance when this cell is empty or its neighbor takes the current item
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt      = up_valid;
      data_nxt       = up_data;
      data_nxt.rem_u = ge_u ? diff_u[REM_W-1:0] : sh_u[REM_W-1:0];
      data_nxt.rem_v = ge_v ? diff_v[REM_W-1:0] : sh_v[REM_W-1:0];
      data_nxt.quo_u = {up_data.quo_u[COORD_BITS-2:0], ge_u};
      data_nxt.quo_v = {up_data.quo_v[COORD_BITS-2:0], ge_v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Restoring division keeps each remainder below the divisor
  a_rem_invariant: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.rem_u < data_r.den) && (data_r.rem_v < data_r.den))
    else $error("div_cell: remainder escaped divisor range");

  // A stalled item keeps its partial results
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dn_ready |=> valid_r && $stable(data_r))
    else $error("div_cell: item changed while stalled");

  // A saturated u coordinate carries a zero remainder, so its quotient stays zero
  a_sat_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && data_r.sat_u |-> data_r.rem_u == '0 && data_r.quo_u == '0)
    else $error("div_cell: saturated u produced quotient bits");

endmodule

// ----- design/cube_map_face_select_uv.sv -----
// ----------------------------------------------------------------------------
// cube_map_face_select_uv
// Cube map face selection and face texture coordinates for one direction.
// ----------------------------------------------------------------------------
// Takes one direction per cycle and returns its cube face and (u, v) in
// unsigned Q0.COORD_BITS, one result per cycle sustained while out_ready
// stays high. One stage selects the face and sets up the division, then a
// row of COORD_BITS division cells, each producing one quotient bit of both
// u and v, carries the item to the output. Every stage holds its own item
// and stalls only when the stage after it is full, so the input keeps
// accepting while a result waits at the output until all COORD_BITS + 1
// stages hold an item.
// Coordinates equal to 1.0 read 2^COORD_BITS - 1; a zero vector gives face +x,
// both coordinates 0.5 and out_degenerate set.
// ----------------------------------------------------------------------------
module cube_map_face_select_uv (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_x,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_y,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_z,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [cmfs_pkg::FACE_W-1:0]                out_face,
  output logic [cmfs_pkg::COORD_BITS-1:0]            out_coord_u,
  output logic [cmfs_pkg::COORD_BITS-1:0]            out_coord_v,
  output logic                                       out_degenerate
);
  import cmfs_pkg::*;

  localparam int NCELL = COORD_BITS;
  localparam logic [COORD_BITS-1:0] HALF = COORD_BITS'(1) << (COORD_BITS - 1);

  logic  chain_valid [NCELL+1];
  logic  chain_ready [NCELL+1];
  work_t chain_data  [NCELL+1];
  work_t last;

  // Face select and divider setup
  cmfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .dir_x    (in_dir_x),
    .dir_y    (in_dir_y),
    .dir_z    (in_dir_z),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_data  (chain_data[0])
  );

  // Row of division cells, one quotient bit each
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cmfs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  // Last cell is the output register; apply saturation on the way out
  assign last                = chain_data[NCELL];
  assign chain_ready[NCELL]  = out_ready;
  assign out_valid           = chain_valid[NCELL];
  assign out_face            = last.face;
  assign out_degenerate      = last.degen;
  assign out_coord_u         = last.sat_u ? '1 : last.quo_u;
  assign out_coord_v         = last.sat_v ? '1 : last.quo_v;

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_face <= FACE_NEG_Z)
    else $error("top: face code out of range");

  a_degen_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_face == FACE_POS_X && out_coord_u == HALF && out_coord_v == HALF)
    else $error("top: zero vector not mapped to face center");

  a_accept_with_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !chain_valid[0] |-> in_ready)
    else $error("top: input blocked while front stage empty");

endmodule

// ----- tb/cmfs_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cmfs_checker
// Watches both channels of the cube map face select block, computes the face
// and (u, v) of every accepted direction and compares each result in order.
// ----------------------------------------------------------------------------
module cmfs_checker (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  input  logic                                       in_ready,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_x,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_y,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] in_dir_z,
  input  logic                                       out_valid,
  input  logic                                       out_ready,
  input  logic [cmfs_pkg::FACE_W-1:0]                out_face,
  input  logic [cmfs_pkg::COORD_BITS-1:0]            out_coord_u,
  input  logic [cmfs_pkg::COORD_BITS-1:0]            out_coord_v,
  input  logic                                       out_degenerate,
  output int                                         n_fail,
  output int                                         n_pending,
  output int                                         n_checked
);
  import cmfs_pkg::*;

  typedef struct {
    face_t                 face;
    logic [COORD_BITS-1:0] coord_u;
    logic [COORD_BITS-1:0] coord_v;
    logic                  degenerate;
  } face_uv_t;

  face_uv_t face_uv_q[$];
  face_uv_t oldest;
  int       n_bad;

  // Scale a minor component onto the face: floor((a + m) * 2^N / (2m)), saturated
  function automatic logic [COORD_BITS-1:0] face_coord(longint minor, longint major_mag);
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    longint unsigned lim;
    num = longint'(minor + major_mag) << COORD_BITS;
    den = longint'(major_mag) * 2;
    quo = num / den;
    lim = (64'd1 << COORD_BITS) - 1;
    if (quo > lim) quo = lim;
    return quo[COORD_BITS-1:0];
  endfunction

  // Pick the major axis face and its two minor components
  function automatic face_uv_t face_uv(logic signed [COMPONENT_BITS-1:0] dx,
                                       logic signed [COMPONENT_BITS-1:0] dy,
                                       logic signed [COMPONENT_BITS-1:0] dz);
    longint x, y, z, ax, ay, az, a, b, m;
    face_uv_t r;
    x = longint'(dx);
    y = longint'(dy);
    z = longint'(dz);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    r.degenerate = 1'b0;
    if (x == 0 && y == 0 && z == 0) begin
      r.face       = FACE_POS_X;
      r.coord_u    = COORD_BITS'(1) << (COORD_BITS - 1);
      r.coord_v    = COORD_BITS'(1) << (COORD_BITS - 1);
      r.degenerate = 1'b1;
      return r;
    end
    if (x >= ay && x >= az) begin
      r.face = FACE_POS_X; a = z;  b = y;  m = ax;
    end else if (-x > ay && -x > az) begin
      r.face = FACE_NEG_X; a = -z; b = y;  m = ax;
    end else if (y >= az && y >= ax) begin
      r.face = FACE_POS_Y; a = x;  b = z;  m = ay;
    end else if (-y > az && -y > ax) begin
      r.face = FACE_NEG_Y; a = x;  b = -z; m = ay;
    end else if (z >= ax && z >= ay) begin
      r.face = FACE_POS_Z; a = -x; b = y;  m = az;
    end else if (-z > ax && -z > ay) begin
      r.face = FACE_NEG_Z; a = x;  b = y;  m = az;
    end else if (-x >= ay && -x >= az) begin
      // largest magnitude shared by two negative axes: lowest face wins
      r.face = FACE_NEG_X; a = -z; b = y;  m = ax;
    end else if (-y >= az && -y >= ax) begin
      r.face = FACE_NEG_Y; a = x;  b = -z; m = ay;
    end else begin
      r.face = FACE_NEG_Z; a = x;  b = y;  m = az;
    end
    r.coord_u = face_coord(a, m);
    r.coord_v = face_coord(b, m);
    return r;
  endfunction

  // Retire results first, then queue the prediction for a new transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      face_uv_q.delete();
      n_fail    <= 0;
      n_pending <= 0;
      n_checked <= 0;
    end else begin
      n_bad = 0;
      if (out_valid && out_ready) begin
        if (face_uv_q.size() == 0) begin
          $error("result with no direction outstanding: face %0d u %0d v %0d degenerate %0b",
                 out_face, out_coord_u, out_coord_v, out_degenerate);
          n_bad = n_bad + 1;
        end else begin
          oldest = face_uv_q.pop_front();
          n_checked <= n_checked + 1;
          if (out_face !== oldest.face) begin
            $error("face: expected %0d actual %0d", oldest.face, out_face);
            n_bad = n_bad + 1;
          end
          if (out_coord_u !== oldest.coord_u) begin
            $error("coord_u: expected %0d actual %0d", oldest.coord_u, out_coord_u);
            n_bad = n_bad + 1;
          end
          if (out_coord_v !== oldest.coord_v) begin
            $error("coord_v: expected %0d actual %0d", oldest.coord_v, out_coord_v);
            n_bad = n_bad + 1;
          end
          if (out_degenerate !== oldest.degenerate) begin
            $error("degenerate: expected %0b actual %0b", oldest.degenerate, out_degenerate);
            n_bad = n_bad + 1;
          end
        end
      end
      n_fail <= n_fail + n_bad;
      if (in_valid && in_ready) begin
        face_uv_q.push_back(face_uv(in_dir_x, in_dir_y, in_dir_z));
      end
      n_pending <= face_uv_q.size();
    end
  end

endmodule

// ----- tb/cube_map_face_select_uv_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cube_map_face_select_uv_tb
// Drives directions into the cube map face select block under three idle
// profiles and a long output stall; the checker predicts and compares.
// ----------------------------------------------------------------------------
module cube_map_face_select_uv_tb;
  import cmfs_pkg::*;

  localparam int LATENCY      = COORD_BITS + 1;
  localparam int STALL_CYCLES = 90;
  localparam int WATCHDOG_MAX = 3000;
  localparam int PHASE_ITEMS  = 150;

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;

  logic  clk            = 1'b0;
  logic  rst_n          = 1'b0;
  logic  in_valid       = 1'b0;
  logic  in_ready;
  comp_t in_dir_x       = '0;
  comp_t in_dir_y       = '0;
  comp_t in_dir_z       = '0;
  logic  out_valid;
  logic  out_ready      = 1'b0;
  logic [FACE_W-1:0]     out_face;
  logic [COORD_BITS-1:0] out_coord_u;
  logic [COORD_BITS-1:0] out_coord_v;
  logic  out_degenerate;

  int n_fail;
  int n_pending;
  int n_checked;
  int snd_idle    = 24;
  int rcv_idle    = 66;
  int stall_reqs  = 0;
  int stall_seen  = 0;
  int stall_left  = 0;
  int n_sent      = 0;
  int idle_cycles = 0;

  cube_map_face_select_uv dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_dir_z      (in_dir_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_face      (out_face),
    .out_coord_u   (out_coord_u),
    .out_coord_v   (out_coord_v),
    .out_degenerate(out_degenerate)
  );

  cmfs_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_dir_z      (in_dir_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_face      (out_face),
    .out_coord_u   (out_coord_u),
    .out_coord_v   (out_coord_v),
    .out_degenerate(out_degenerate),
    .n_fail        (n_fail),
    .n_pending     (n_pending),
    .n_checked     (n_checked)
  );

  always #5 clk = ~clk;

  // Receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (stall_seen != stall_reqs) begin
      stall_seen = stall_reqs;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Offer one direction after a random gap and hold it until the transfer
  task automatic send_dir(input int x, input int y, input int z);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dir_x <= comp_t'(x);
    in_dir_y <= comp_t'(y);
    in_dir_z <= comp_t'(z);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  function automatic comp_t signed_mag(int m);
    return ($urandom_range(0, 1) != 0) ? comp_t'(m) : comp_t'(-m);
  endfunction

  function automatic comp_t edge_value();
    case ($urandom_range(0, 6))
      0: return comp_t'(-32768);
      1: return comp_t'(-32767);
      2: return comp_t'(-1);
      3: return comp_t'(0);
      4: return comp_t'(1);
      5: return comp_t'(32767);
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Random direction: mix of full range, small values, ties, edges, one dominant axis
  task automatic send_random_dir();
    comp_t c[3];
    int    m;
    int    k;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      foreach (c[i]) c[i] = comp_t'($urandom);
    end else if (pick < 45) begin
      foreach (c[i]) c[i] = comp_t'(int'($urandom_range(0, 8)) - 4);
    end else if (pick < 65) begin
      m = $urandom_range(1, 32768);
      k = $urandom_range(0, 2);
      c[k] = (m == 32768) ? comp_t'(-32768) : signed_mag(m);
      c[(k + 1) % 3] = (m == 32768) ? comp_t'(-32768) : signed_mag(m);
      c[(k + 2) % 3] = signed_mag($urandom_range(0, (m == 32768) ? 32767 : m));
    end else if (pick < 80) begin
      foreach (c[i]) c[i] = edge_value();
    end else begin
      k = $urandom_range(0, 2);
      foreach (c[i]) c[i] = comp_t'(int'($urandom_range(0, 32767)) - 16384);
      c[k] = ($urandom_range(0, 9) == 0) ? comp_t'(-32768)
                                         : signed_mag($urandom_range(16384, 32767));
    end
    send_dir(int'(c[0]), int'(c[1]), int'(c[2]));
  endtask

  initial begin
    // Hold reset, then release at a clock edge
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, each face, ties, saturation, full-scale negatives
    send_dir(0, 0, 0);
    send_dir(16384, 100, -100);
    send_dir(-16384, 100, -100);
    send_dir(100, 16384, -100);
    send_dir(100, -16384, -100);
    send_dir(100, -100, 16384);
    send_dir(100, -100, -16384);
    send_dir(32767, 32767, 32767);
    send_dir(-32768, 0, 0);
    send_dir(0, 0, -32768);
    send_dir(-32768, -32768, 0);
    send_dir(-32768, -32768, -32768);
    send_dir(0, -5, -5);
    send_dir(-7, 0, -7);
    send_dir(-1, -1, -1);
    send_dir(-3, 3, 0);
    send_dir(0, 1, 1);
    send_dir(100, 0, 100);
    send_dir(100, 0, -100);
    send_dir(32767, -32768, 0);
    send_dir(-32768, 32767, -32768);
    send_dir(1, 0, 0);
    send_dir(0, 0, -1);
    send_dir(-32768, 32767, 32767);

    // Sender lightly idle, receiver mostly idle
    repeat (PHASE_ITEMS) send_random_dir();
    drain();

    // Swap the idle profiles
    snd_idle <= 66;
    rcv_idle <= 24;
    repeat (PHASE_ITEMS) send_random_dir();
    drain();

    // Neither side idles; a long output hold-off fills the pipeline
    snd_idle <= 0;
    rcv_idle <= 0;
    repeat (PHASE_ITEMS / 3) send_random_dir();
    stall_reqs <= stall_reqs + 1;
    repeat (PHASE_ITEMS - PHASE_ITEMS / 3) send_random_dir();
    drain();

    repeat (2 * LATENCY) @(posedge clk);

    $display("Run covered %0d directions (directed corners, ties, zero vector, random mix)",
             n_sent);
    $display("under three idle profiles and a long output stall; %0d results compared",
             n_checked);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
